// File: hdl/rcrl_pkg.sv
// Package for the ring code run-length decoder.
// Holds the result beat type, config register codes, reset values and queue sizing.
// No dependencies.
package rcrl_pkg;

  localparam int COUNT_BITS_DEFAULT = 12;

  // Reset values of the config registers
  localparam logic [7:0]  XOR_MASK_RESET     = 8'h96;
  localparam logic [15:0] WINDOW_ZERO_RESET  = 16'd3333;
  localparam logic [15:0] WINDOW_ONE_RESET   = 16'd6159;
  localparam logic [15:0] WINDOW_TWO_RESET   = 16'd9756;
  localparam logic [15:0] WINDOW_THREE_RESET = 16'd13868;

  localparam int NUM_WINDOWS = 4;

  // Result queue: two beats may enter per item, one leaves per cycle unless the output stalls
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CFG_XOR_MASK     = 3'd0,
    CFG_WINDOW_ZERO  = 3'd1,
    CFG_WINDOW_ONE   = 3'd2,
    CFG_WINDOW_TWO   = 3'd3,
    CFG_WINDOW_THREE = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_GAP_FAIL  = 2'd1,
    ST_NO_GAPS   = 2'd2,
    ST_LEFTOVER  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0]                  xor_mask;
    logic [NUM_WINDOWS-1:0][15:0] window;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    status_t    status;
    logic [7:0] byte_total;
    logic       last_of_run;
  } result_t;

  // Beats produced by one processed sample, first beat in res0
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

// File: hdl/rcrl_decode.sv
// Run counting, symbol classification, byte packing and end-of-scan status.
// Holds all per-scan state; one sample is processed per enabled cycle.
// Depends on rcrl_pkg.
module rcrl_decode #(
  parameter int COUNT_BITS = rcrl_pkg::COUNT_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             hit,
  input  logic             final_sample,
  input  rcrl_pkg::cfg_t   cfg,
  output rcrl_pkg::push_t  push
);

  localparam int W = COUNT_BITS;
  localparam logic [W-1:0] RUN_MAX = '1;

  logic [W-1:0] hit_run, gap_run, latest_gap, largest_gap;
  logic [1:0]   gaps_seen, symbol_slot;
  logic [5:0]   partial_byte;
  logic [7:0]   bytes_done;

  logic [W-1:0] hit_run_next, gap_run_next, latest_gap_next, largest_gap_next;
  logic [1:0]   gaps_seen_next, symbol_slot_next;
  logic [5:0]   partial_byte_next;
  logic [7:0]   bytes_done_next;

  logic [rcrl_pkg::NUM_WINDOWS-1:0] win_match;
  logic       sym_valid;
  logic [1:0] sym;

  logic         gap_close;
  logic [W-1:0] gap_closed;
  logic         byte_emit;
  logic [7:0]   byte_val;
  logic [W+2:0] earlier_x6, latest_x5;
  rcrl_pkg::status_t   st;
  rcrl_pkg::result_t   byte_res, status_res;

  // Window compares on the open hit run; lowest matching window wins
  always_comb begin
    for (int i = 0; i < rcrl_pkg::NUM_WINDOWS; i++) begin
      win_match[i] = (hit_run >= W'(cfg.window[i][7:0])) &&
                     (hit_run <= W'(cfg.window[i][15:8]));
    end
    sym_valid = |win_match;
    sym       = 2'd0;
    for (int i = rcrl_pkg::NUM_WINDOWS - 1; i >= 0; i--) begin
      if (win_match[i]) sym = 2'(i);
    end
  end

  always_comb begin
    hit_run_next      = hit_run;
    gap_run_next      = gap_run;
    latest_gap_next   = latest_gap;
    largest_gap_next  = largest_gap;
    gaps_seen_next    = gaps_seen;
    symbol_slot_next  = symbol_slot;
    partial_byte_next = partial_byte;
    bytes_done_next   = bytes_done;
    byte_emit         = 1'b0;
    byte_val          = '0;

    if (hit) begin
      if (hit_run != RUN_MAX) hit_run_next = hit_run + 1'b1;
    end else begin
      if (hit_run != '0) begin
        if (sym_valid) begin
          if (symbol_slot == 2'd3) begin
            byte_emit         = 1'b1;
            byte_val          = {sym, partial_byte} ^ cfg.xor_mask;
            if (bytes_done != 8'hFF) bytes_done_next = bytes_done + 1'b1;
            symbol_slot_next  = '0;
            partial_byte_next = '0;
          end else begin
            partial_byte_next = partial_byte | (6'(sym) << {symbol_slot, 1'b0});
            symbol_slot_next  = symbol_slot + 1'b1;
          end
        end
        hit_run_next = '0;
      end
      if (gap_run != RUN_MAX) gap_run_next = gap_run + 1'b1;
    end

    // A gap closes on the hit that follows it, or at the end of the scan.
    // On a background sample the gap count is never zero here.
    gap_close  = hit ? (gap_run != '0) : final_sample;
    gap_closed = gap_run_next;
    if (gap_close) begin
      if (gaps_seen != 2'd0 && latest_gap > largest_gap) largest_gap_next = latest_gap;
      latest_gap_next = gap_closed;
      if (gaps_seen != 2'd3) gaps_seen_next = gaps_seen + 1'b1;
      gap_run_next = '0;
    end

    // earlier * 6 > latest * 5, exact form of the 1.2 ratio
    earlier_x6 = ((W+3)'(largest_gap_next) << 2) + ((W+3)'(largest_gap_next) << 1);
    latest_x5  = ((W+3)'(latest_gap_next) << 2) + (W+3)'(latest_gap_next);

    if (gaps_seen_next == 2'd0)
      st = rcrl_pkg::ST_NO_GAPS;
    else if (gaps_seen_next >= 2'd2 && earlier_x6 > latest_x5)
      st = rcrl_pkg::ST_GAP_FAIL;
    else if (symbol_slot_next != 2'd0)
      st = rcrl_pkg::ST_LEFTOVER;
    else
      st = rcrl_pkg::ST_OK;

    byte_res             = '0;
    byte_res.kind        = rcrl_pkg::KIND_BYTE;
    byte_res.byte_value  = byte_val;
    byte_res.byte_index  = bytes_done;
    byte_res.status      = rcrl_pkg::ST_OK;
    byte_res.last_of_run = !final_sample;

    status_res             = '0;
    status_res.kind        = rcrl_pkg::KIND_STATUS;
    status_res.status      = st;
    status_res.byte_total  = bytes_done_next;
    status_res.last_of_run = 1'b1;

    push = '0;
    if (byte_emit) begin
      push.res0 = byte_res;
      if (final_sample) begin
        push.res1 = status_res;
        push.cnt  = 2'd2;
      end else begin
        push.cnt  = 2'd1;
      end
    end else if (final_sample) begin
      push.res0 = status_res;
      push.cnt  = 2'd1;
    end

    if (final_sample) begin
      hit_run_next      = '0;
      gap_run_next      = '0;
      latest_gap_next   = '0;
      largest_gap_next  = '0;
      gaps_seen_next    = '0;
      symbol_slot_next  = '0;
      partial_byte_next = '0;
      bytes_done_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_run      <= '0;
      gap_run      <= '0;
      latest_gap   <= '0;
      largest_gap  <= '0;
      gaps_seen    <= '0;
      symbol_slot  <= '0;
      partial_byte <= '0;
      bytes_done   <= '0;
    end else if (step) begin
      hit_run      <= hit_run_next;
      gap_run      <= gap_run_next;
      latest_gap   <= latest_gap_next;
      largest_gap  <= largest_gap_next;
      gaps_seen    <= gaps_seen_next;
      symbol_slot  <= symbol_slot_next;
      partial_byte <= partial_byte_next;
      bytes_done   <= bytes_done_next;
    end
  end

endmodule

// File: hdl/rcrl_queue.sv
// Result queue: takes up to two beats per cycle, hands out one per cycle while pop is high.
// The head entry at the read pointer drives the head port through a combinational read.
// Depends on rcrl_pkg.
module rcrl_queue (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rcrl_pkg::push_t                       push,
  input  logic                                  pop,
  output rcrl_pkg::result_t                     head,
  output logic [rcrl_pkg::QUEUE_CNT_BITS-1:0]   count
);

  localparam int PB = rcrl_pkg::QUEUE_PTR_BITS;
  localparam int CB = rcrl_pkg::QUEUE_CNT_BITS;

  rcrl_pkg::result_t mem [rcrl_pkg::QUEUE_DEPTH];
  logic [PB-1:0] wr_ptr, rd_ptr;
  logic [PB-1:0] wr_ptr_plus1;

  assign wr_ptr_plus1 = wr_ptr + 1'b1;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PB'(push.cnt);
      rd_ptr <= rd_ptr + PB'(pop);
      count  <= count + CB'(push.cnt) - CB'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_ptr] <= push.res0;
    if (push.cnt == 2'd2) mem[wr_ptr_plus1] <= push.res1;
  end

endmodule

// File: hdl/ring_code_run_length_decoder_core.sv
// Ring code run-length decoder, top level.
// Config registers, input register, decode logic and result queue.
// Depends on rcrl_pkg, rcrl_decode, rcrl_queue.
//
// Usage:
//   Input channel (in_valid / in_stall, hit, final_sample): one ring sample per
//   beat, taken into an input register and processed once the queue has room
//   for two beats; a new sample can be taken every cycle while not stalled.
//   Output channel (out_valid / out_stall): result beats, kind 0 for a decoded
//   byte, kind 1 for the end-of-scan status. A sample gives zero, one or two
//   beats; last_of_run marks the final beat of a sample.
//   Samples wait in the input register; result beats wait in the result queue.
//   Throughput: one sample per cycle unless in_stall is high; the output moves
//   one beat per cycle unless out_stall is high, so a sample that yields two
//   beats (byte plus status) costs one extra output slot. A four-entry result
//   queue absorbs this; in_stall rises when the queue cannot take two more
//   beats, and stays high while out_stall holds the queue full.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): always ready;
//   write only while the block is idle.
//   Reset (rst, synchronous): clears scan state and queue, restores register
//   defaults (mask 0x96 and the four default count windows).
module ring_code_run_length_decoder_core #(
  parameter int COUNT_BITS = rcrl_pkg::COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        hit,
  input  logic        final_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  byte_value,
  output logic [7:0]  byte_index,
  output logic [1:0]  status,
  output logic [7:0]  byte_total,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CB = rcrl_pkg::QUEUE_CNT_BITS;

  rcrl_pkg::cfg_t    cfg;
  logic              in_full;
  logic              hit_q, final_q;
  logic              step;
  logic              in_accept;
  rcrl_pkg::push_t   push;
  rcrl_pkg::result_t head;
  logic [CB-1:0]     count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.xor_mask  <= rcrl_pkg::XOR_MASK_RESET;
      cfg.window[0] <= rcrl_pkg::WINDOW_ZERO_RESET;
      cfg.window[1] <= rcrl_pkg::WINDOW_ONE_RESET;
      cfg.window[2] <= rcrl_pkg::WINDOW_TWO_RESET;
      cfg.window[3] <= rcrl_pkg::WINDOW_THREE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcrl_pkg::CFG_XOR_MASK:     cfg.xor_mask  <= cfg_data[7:0];
        rcrl_pkg::CFG_WINDOW_ZERO:  cfg.window[0] <= cfg_data;
        rcrl_pkg::CFG_WINDOW_ONE:   cfg.window[1] <= cfg_data;
        rcrl_pkg::CFG_WINDOW_TWO:   cfg.window[2] <= cfg_data;
        rcrl_pkg::CFG_WINDOW_THREE: cfg.window[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Process the held sample once the queue has room for two beats
  assign step      = in_full && (count <= CB'(rcrl_pkg::QUEUE_DEPTH - 2));
  assign in_stall  = in_full && !step;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hit_q   <= hit;
      final_q <= final_sample;
    end
  end

  rcrl_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .hit          (hit_q),
    .final_sample (final_q),
    .cfg          (cfg),
    .push         (push)
  );

  rcrl_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (step ? push : '0),
    .pop   (out_valid && !out_stall),
    .head  (head),
    .count (count)
  );

  assign out_valid   = (count != '0);
  assign kind        = head.kind;
  assign byte_value  = head.byte_value;
  assign byte_index  = head.byte_index;
  assign status      = head.status;
  assign byte_total  = head.byte_total;
  assign last_of_run = head.last_of_run;

endmodule

// File: hdl/rcrl_checker.sv
// Port-level checks for the ring code run-length decoder, bound to the top level.
// Depends on rcrl_pkg and ring_code_run_length_decoder_core.
module rcrl_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       kind,
  input logic [7:0] byte_value,
  input logic [7:0] byte_index,
  input logic [1:0] status,
  input logic [7:0] byte_total,
  input logic       last_of_run
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(kind) && $stable(byte_value) &&
      $stable(byte_index) && $stable(status) && $stable(byte_total) &&
      $stable(last_of_run))
    else $error("stalled output payload changed");

  // Status always closes its sample
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == rcrl_pkg::KIND_STATUS) |-> last_of_run)
    else $error("status beat without last_of_run");

  // A byte that is not last is followed at once by its status
  a_byte_then_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (kind == rcrl_pkg::KIND_BYTE) && !last_of_run
      |=> out_valid && (kind == rcrl_pkg::KIND_STATUS))
    else $error("byte of a final sample not followed by status");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == rcrl_pkg::KIND_STATUS) && byte_value == 8'd0 &&
      byte_index == 8'd0) || ((kind == rcrl_pkg::KIND_BYTE) &&
      status == rcrl_pkg::ST_OK && byte_total == 8'd0))
    else $error("unused result fields not zero");

endmodule

bind ring_code_run_length_decoder_core rcrl_checker u_rcrl_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .kind        (kind),
  .byte_value  (byte_value),
  .byte_index  (byte_index),
  .status      (status),
  .byte_total  (byte_total),
  .last_of_run (last_of_run)
);
